### rtl/core/ccmc_pkg.sv
// shared constants and types for the minimum-coin change block
`default_nettype none

package ccmc_pkg;

  localparam int unsigned VAL_W = 10;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ZERO  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

### rtl/core/ccmc_coin_store.sv
// coin denomination store with fill count and drop flag
`default_nettype none

module ccmc_coin_store #(
  parameter int unsigned MAX_COINS = 16,
  parameter int unsigned KW        = 5,
  parameter int unsigned SW        = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_en_i,
  input  wire logic [ccmc_pkg::VAL_W-1:0] load_value_i,
  input  wire logic                     clear_i,
  input  wire logic                     rd_en_i,
  input  wire logic [SW-1:0]            rd_addr_i,
  output logic      [ccmc_pkg::VAL_W-1:0] rd_data_o,
  output logic      [KW-1:0]            count_o,
  output logic                          overflow_o
);

  logic [ccmc_pkg::VAL_W-1:0] mem [MAX_COINS];
  logic [KW-1:0]              count_q, count_d;
  logic                       overflow_q, overflow_d;
  logic                       full;
  logic                       store_en;

  assign full     = (count_q == KW'(MAX_COINS));
  assign store_en = load_en_i && (load_value_i != '0) && !full;

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (clear_i) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end else if (load_en_i && (load_value_i != '0)) begin
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d = count_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  // zero-based fill: the next free slot is the current count
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[count_q[SW-1:0]] <= load_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign count_o    = count_q;
  assign overflow_o = overflow_q;

endmodule

`default_nettype wire

### rtl/core/ccmc_best_mem.sv
// best-count table memory, one write and one registered read port
`default_nettype none

module ccmc_best_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 11
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/coin_change_min_coins.sv
// minimum-coin change top level: coin loading, table pass sequencer and result
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+---------------------------
//  item in | coin_value_i, target_sum_i, last_coin_i        | taken when start & !busy
//  result  | min_coins_o, reachable_o, coins_dropped_o      | done_o strobe, one cycle
//
// a coin item that is not last leaves busy low
// a last item runs the table pass, with one coin-store read per coin and entry
//   and one table read for each coin that fits the entry
// reset clears the sequencer, the coin count and the drop flag; memories are not cleared
// the result strobe cannot be stalled; busy stays high until the strobe cycle ends
`default_nettype none

module coin_change_min_coins #(
  parameter int unsigned MAX_SUM   = 1023,
  parameter int unsigned MAX_COINS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ccmc_pkg::VAL_W-1:0] coin_value_i,
  input  wire logic [ccmc_pkg::VAL_W-1:0] target_sum_i,
  input  wire logic                       last_coin_i,
  output logic                            done_o,
  output logic      [ccmc_pkg::VAL_W-1:0] min_coins_o,
  output logic                            reachable_o,
  output logic                            coins_dropped_o
);

  // table address and count width; counts never exceed MAX_SUM
  localparam int unsigned AW    = $clog2(MAX_SUM + 1);
  localparam int unsigned CW    = AW;
  localparam int unsigned DW    = CW + 1;
  // common width for comparing coin values with table indexes
  localparam int unsigned IW    = (AW > ccmc_pkg::VAL_W) ? AW : ccmc_pkg::VAL_W;
  localparam int unsigned OW    = (CW > ccmc_pkg::VAL_W) ? CW : ccmc_pkg::VAL_W;
  localparam int unsigned KW    = $clog2(MAX_COINS + 1);
  localparam int unsigned SW    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

  ccmc_pkg::state_e state_q, state_d;

  logic          accept;
  logic          too_big;

  logic [AW-1:0] goal_q, goal_d;
  logic [AW-1:0] i_q, i_d;
  logic [KW-1:0] k_q, k_d;

  // two-stage read pipeline: coin read, then table read
  logic          v1_q, v1_d;
  logic          v2_q, v2_d;

  // running minimum for the entry being built
  logic          found_q, found_d;
  logic [CW-1:0] best_q, best_d;

  // result registers
  logic          res_reach_q, res_reach_d;
  logic [CW-1:0] res_cnt_q, res_cnt_d;
  logic          res_drop_q, res_drop_d;

  // coin store ports
  logic                       coin_rd_en;
  logic [ccmc_pkg::VAL_W-1:0] coin_rdata;
  logic [KW-1:0]              coin_count;
  logic                       coin_overflow;
  logic                       store_clear;

  // table ports
  logic          tab_wr_en;
  logic [AW-1:0] tab_wr_addr;
  logic [DW-1:0] tab_wr_data;
  logic          tab_rd_en;
  logic [AW-1:0] tab_rd_addr;
  logic [DW-1:0] tab_rdata;

  logic [IW-1:0] coin_ext;
  logic [IW-1:0] i_ext;
  logic [IW-1:0] diff;
  logic          coin_fits;
  logic [CW-1:0] best_plus;
  logic [OW-1:0] cnt_ext;
  logic [IW-1:0] tgt_ext;

  assign accept   = start && !busy;
  // target beyond the table is reported unreachable without a pass
  assign too_big  = ({22'd0, target_sum_i} > 32'(MAX_SUM));
  assign tgt_ext  = IW'(target_sum_i);

  assign coin_ext  = IW'(coin_rdata);
  assign i_ext     = IW'(i_q);
  assign coin_fits = (coin_ext <= i_ext);
  assign diff      = i_ext - coin_ext;
  assign best_plus = best_q + CW'(1);

  // stage b: coin value is back, look up entry i - c when the coin fits
  assign tab_rd_en   = v1_q && coin_fits;
  assign tab_rd_addr = diff[AW-1:0];

  ccmc_coin_store #(
    .MAX_COINS (MAX_COINS),
    .KW        (KW),
    .SW        (SW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (accept),
    .load_value_i (coin_value_i),
    .clear_i      (store_clear),
    .rd_en_i      (coin_rd_en),
    .rd_addr_i    (k_q[SW-1:0]),
    .rd_data_o    (coin_rdata),
    .count_o      (coin_count),
    .overflow_o   (coin_overflow)
  );

  ccmc_best_mem #(
    .DEPTH (MAX_SUM + 1),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tab_wr_en),
    .wr_addr_i (tab_wr_addr),
    .wr_data_i (tab_wr_data),
    .rd_en_i   (tab_rd_en),
    .rd_addr_i (tab_rd_addr),
    .rd_data_o (tab_rdata)
  );

  always_comb begin
    state_d     = state_q;
    goal_d      = goal_q;
    i_d         = i_q;
    k_d         = k_q;
    v1_d        = 1'b0;
    v2_d        = tab_rd_en;
    found_d     = found_q;
    best_d      = best_q;
    res_reach_d = res_reach_q;
    res_cnt_d   = res_cnt_q;
    res_drop_d  = res_drop_q;
    coin_rd_en  = 1'b0;
    store_clear = 1'b0;
    tab_wr_en   = 1'b0;
    tab_wr_addr = i_q;
    tab_wr_data = '0;

    // stage c: table entry is back, fold it into the running minimum
    if (v2_q && tab_rdata[CW]) begin
      if (!found_q || (tab_rdata[CW-1:0] < best_q)) begin
        best_d  = tab_rdata[CW-1:0];
        found_d = 1'b1;
      end
    end

    case (state_q)
      ccmc_pkg::S_IDLE: begin
        if (accept && last_coin_i) begin
          if (too_big) begin
            res_reach_d = 1'b0;
            res_cnt_d   = '0;
            state_d     = ccmc_pkg::S_DONE;
          end else begin
            goal_d  = tgt_ext[AW-1:0];
            state_d = ccmc_pkg::S_ZERO;
          end
        end
      end
      ccmc_pkg::S_ZERO: begin
        // entry 0 is reachable with no coins
        tab_wr_en   = 1'b1;
        tab_wr_addr = '0;
        tab_wr_data = {1'b1, {CW{1'b0}}};
        i_d         = AW'(1);
        k_d         = '0;
        found_d     = 1'b0;
        best_d      = '0;
        if (goal_q == '0) begin
          res_reach_d = 1'b1;
          res_cnt_d   = '0;
          state_d     = ccmc_pkg::S_DONE;
        end else begin
          state_d = ccmc_pkg::S_SCAN;
        end
      end
      ccmc_pkg::S_SCAN: begin
        // stage a: one coin read per cycle
        if (k_q == coin_count) begin
          state_d = ccmc_pkg::S_DRAIN;
        end else begin
          coin_rd_en = 1'b1;
          v1_d       = 1'b1;
          k_d        = k_q + KW'(1);
        end
      end
      ccmc_pkg::S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ccmc_pkg::S_WRITE;
        end
      end
      ccmc_pkg::S_WRITE: begin
        // entry i is written before any read for i + 1 is issued
        tab_wr_en   = 1'b1;
        tab_wr_data = found_q ? {1'b1, best_plus} : '0;
        if (i_q == goal_q) begin
          res_reach_d = found_q;
          res_cnt_d   = found_q ? best_plus : '0;
          state_d     = ccmc_pkg::S_DONE;
        end else begin
          i_d     = i_q + AW'(1);
          k_d     = '0;
          found_d = 1'b0;
          best_d  = '0;
          state_d = ccmc_pkg::S_SCAN;
        end
      end
      ccmc_pkg::S_DONE: begin
        // drop flag covers the last item's own coin; then start a fresh set
        res_drop_d  = coin_overflow;
        store_clear = 1'b1;
        state_d     = ccmc_pkg::S_IDLE;
      end
      default: begin
        state_d = ccmc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccmc_pkg::S_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    goal_q      <= goal_d;
    i_q         <= i_d;
    k_q         <= k_d;
    found_q     <= found_d;
    best_q      <= best_d;
    res_reach_q <= res_reach_d;
    res_cnt_q   <= res_cnt_d;
    res_drop_q  <= res_drop_d;
  end

  // strobe in the cycle after the done state, with the drop flag captured there
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ccmc_pkg::S_DONE);
    end
  end

  assign cnt_ext         = OW'(res_cnt_q);
  assign busy            = (state_q != ccmc_pkg::S_IDLE) || done_q;
  assign done_o          = done_q;
  assign min_coins_o     = cnt_ext[ccmc_pkg::VAL_W-1:0];
  assign reachable_o     = res_reach_q;
  assign coins_dropped_o = res_drop_q;

endmodule

`default_nettype wire

### bench/coin_change_checker.sv
// coin change checker: watches item and result channels, predicts each result and compares
module coin_change_checker #(
  parameter int unsigned MAX_SUM   = 1023,
  parameter int unsigned MAX_COINS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ccmc_pkg::VAL_W-1:0] coin_value_i,
  input  logic [ccmc_pkg::VAL_W-1:0] target_sum_i,
  input  logic                       last_coin_i,
  input  logic                       done_o,
  input  logic [ccmc_pkg::VAL_W-1:0] min_coins_o,
  input  logic                       reachable_o,
  input  logic                       coins_dropped_o,
  output int                         mismatch_count,
  output int                         results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW = ccmc_pkg::VAL_W;

  typedef struct packed {
    logic [VW-1:0] coins;
    logic          reach;
    logic          dropped;
  } change_result_t;

  change_result_t change_q[$];

  // own copy of the denomination store and the table, bit 10 of a table entry is reachable
  logic [VW-1:0] denom_store [MAX_COINS];
  int unsigned   denom_count;
  bit            drop_seen;
  logic [VW:0]   fewest_table [MAX_SUM+1];

  initial mismatch_count = 0;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ns  %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  task automatic predict_change(input logic [VW-1:0] coin, input logic [VW-1:0] goal,
                                input logic last);
    change_result_t res;
    logic [VW:0]    entry;
    logic [VW:0]    probe;
    logic [VW-1:0]  fewest;
    bit             found;
    if (coin != '0) begin
      if (denom_count < MAX_COINS) begin
        denom_store[denom_count] = coin;
        denom_count++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (last) begin
      entry = '0;
      if (goal <= MAX_SUM) begin
        fewest_table[0] = {1'b1, {VW{1'b0}}};
        for (int i = 1; i <= int'(goal); i++) begin
          found  = 1'b0;
          fewest = '0;
          for (int k = 0; k < int'(denom_count); k++) begin
            if (int'(denom_store[k]) <= i) begin
              probe = fewest_table[i - int'(denom_store[k])];
              if (probe[VW] && (!found || probe[VW-1:0] < fewest)) begin
                fewest = probe[VW-1:0];
                found  = 1'b1;
              end
            end
          end
          fewest_table[i] = found ? {1'b1, VW'(fewest + 1'b1)} : '0;
        end
        entry = fewest_table[goal];
      end
      res.coins   = entry[VW] ? entry[VW-1:0] : '0;
      res.reach   = entry[VW];
      res.dropped = drop_seen;
      change_q.push_back(res);
      denom_count = 0;
      drop_seen   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    change_result_t want;
    if (!rst_ni) begin
      denom_count = 0;
      drop_seen   = 1'b0;
      change_q.delete();
      results_pending <= 0;
    end else begin
      if (done_o) begin
        if (change_q.size() == 0) begin
          report_mismatch("result with nothing pending, reachable", 0, reachable_o);
        end else begin
          want = change_q.pop_front();
          if (min_coins_o !== want.coins)
            report_mismatch("min_coins", want.coins, min_coins_o);
          if (reachable_o !== want.reach)
            report_mismatch("reachable", want.reach, reachable_o);
          if (coins_dropped_o !== want.dropped)
            report_mismatch("coins_dropped", want.dropped, coins_dropped_o);
        end
      end
      if (start && !busy)
        predict_change(coin_value_i, target_sum_i, last_coin_i);
      results_pending <= change_q.size();
    end
  end

endmodule

### bench/tb.sv
// testbench top: clock, reset, coin item stimulus and the final verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW = ccmc_pkg::VAL_W;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          start         = 1'b0;
  logic [VW-1:0] coin_value    = '0;
  logic [VW-1:0] target_sum    = '0;
  logic          last_coin     = 1'b0;
  logic          busy;
  logic          done;
  logic [VW-1:0] min_coins;
  logic          reachable;
  logic          coins_dropped;

  int mismatch_count;
  int results_pending;

  // counts items the block acts on: nonzero coins and set closers
  int items_fed = 0;
  // chance of an idle burst before an item, in eighths; zero gives a calm stretch
  int idle_odds = 2;
  // no idling at all near the end of the run
  bit quiet     = 1'b0;
  // full-range targets cost a long table pass, so only a few of them
  int wide_left = 8;

  coin_change_min_coins i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .coin_value_i   (coin_value),
    .target_sum_i   (target_sum),
    .last_coin_i    (last_coin),
    .done_o         (done),
    .min_coins_o    (min_coins),
    .reachable_o    (reachable),
    .coins_dropped_o(coins_dropped)
  );

  coin_change_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .coin_value_i   (coin_value),
    .target_sum_i   (target_sum),
    .last_coin_i    (last_coin),
    .done_o         (done),
    .min_coins_o    (min_coins),
    .reachable_o    (reachable),
    .coins_dropped_o(coins_dropped),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // drive one item and hold it until the block takes it (start high, busy low at an edge)
  // an idle burst drops start first, so start never gets two assignments in one step
  task automatic send_item(input logic [VW-1:0] coin, input logic [VW-1:0] goal,
                           input logic last);
    if (!quiet && idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    start      <= 1'b1;
    coin_value <= coin;
    target_sum <= goal;
    last_coin  <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (coin != '0 || last)
      items_fed++;
  endtask

  // one set of denominations, the final item flagged last and carrying the target
  // the target on earlier items is ignored by the block, so it is random noise
  task automatic play_set(input int n, input logic [VW-1:0] goal, input bit wide_coins);
    logic [VW-1:0] c;
    for (int j = 0; j < n; j++) begin
      if (wide_coins || $urandom_range(0, 7) == 0)
        c = VW'($urandom_range(0, 1023));
      else
        c = VW'($urandom_range(1, 40));
      // a zero coin now and then, which must be skipped without counting
      if ($urandom_range(0, 11) == 0)
        c = '0;
      send_item(c, (j == n - 1) ? goal : VW'($urandom), j == n - 1);
    end
  endtask

  initial begin
    logic [VW-1:0] goal;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no coins at all, target zero: reachable with zero coins
    send_item('0, '0, 1'b1);
    // no coins, nonzero target: unreachable
    send_item('0, 10'd5, 1'b1);
    // zero coin ignored, then 3 and 5 cannot make 7
    send_item('0, 10'd1023, 1'b0);
    send_item(10'd3, 10'd0, 1'b0);
    send_item(10'd5, 10'd7, 1'b1);
    // plain case: 4 and 3 make 6 with two coins
    send_item(10'd4, 10'd0, 1'b0);
    send_item(10'd3, 10'd6, 1'b1);
    // full store plus one more coin: the extra is dropped, top target and top coin value
    for (int j = 0; j < 16; j++)
      send_item((j == 0) ? 10'd1023 : VW'(j * 37 + 1), ~VW'(j), 1'b0);
    send_item(10'd2, 10'd1023, 1'b1);

    // random sets: mostly well formed with small targets, some noise and overflow
    while (items_fed < 550) begin
      idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (items_fed > 450)
        quiet = 1'b1;
      goal = VW'($urandom_range(0, 63));
      if (wide_left > 0 && $urandom_range(0, 24) == 0) begin
        goal = VW'($urandom);
        wide_left--;
      end
      case ($urandom_range(0, 9))
        0: begin
          play_set(1, goal, 1'b1);
        end
        1: begin
          play_set($urandom_range(17, 22), goal, 1'b0);
        end
        2: begin
          play_set($urandom_range(1, 6), goal, 1'b1);
        end
        default: begin
          play_set($urandom_range(1, 6), goal, 1'b0);
        end
      endcase
    end

    // one more edge so the checker's pending count includes the final item
    start <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    // a result needs an item, so a short drain catches any stray strobe
    repeat (32) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // worst case is a few full-range passes plus hundreds of small ones, several times over
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
